@@ rtl/pkrl_pkg.sv @@
// ----------------------------------------------------------------------------
// pkrl_pkg
// shared types and constants of the per-key interval rate limiter
// ----------------------------------------------------------------------------
package pkrl_pkg;

    localparam int BUCKET_BITS = 6;
    localparam int WAYS        = 4;
    localparam int KEY_BITS    = 22;

    localparam int NBUCKETS  = 1 << BUCKET_BITS;
    localparam int KEY_W     = 22;
    localparam int TIME_W    = 48;
    localparam int RAND_W    = 32;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_STEPS = RAND_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [KEY_W-1:0] KEY_MASK = (KEY_BITS >= KEY_W) ? {KEY_W{1'b1}} :
        KEY_W'((64'd1 << KEY_BITS) - 64'd1);

    // commands
    localparam logic CMD_CHECK   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_JITTER_SPAN  = 2'd2;

    // register reset values
    localparam logic             RST_ENABLE       = 1'b1;
    localparam logic [CFG_W-1:0] RST_MIN_INTERVAL = CFG_W'(30000);
    localparam logic [CFG_W-1:0] RST_JITTER_SPAN  = CFG_W'(10000);

    typedef logic [BUCKET_BITS-1:0] bucket_t;
    typedef logic [WAYS-1:0]        way_vec_t;

    typedef struct packed {
        logic              command;
        logic [KEY_W-1:0]  caller_key;
        logic [TIME_W-1:0] now_ms;
        logic [RAND_W-1:0] random_word;
    } pkrl_req_t;

    typedef struct packed {
        logic allowed;
        logic not_recorded;
    } pkrl_rsp_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] next_allowed;
    } way_t;

    typedef way_t [WAYS-1:0] row_t;

    // row write-back towards the table
    typedef struct packed {
        logic     en;
        bucket_t  addr;
        way_vec_t valid;
        row_t     row;
    } pkrl_wr_t;

endpackage

@@ rtl/pkrl_mod.sv @@
// ----------------------------------------------------------------------------
// pkrl_mod
// bit-serial remainder unit, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pkrl_mod (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pkrl_pkg::RAND_W-1:0] dividend,
    input  logic [pkrl_pkg::CFG_W-1:0]  divisor,
    output logic                       busy,
    output logic [pkrl_pkg::CFG_W-1:0]  remainder
);
    import pkrl_pkg::*;

    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [RAND_W-1:0]    dvd_reg;
    logic [CFG_W-1:0]     dsr_reg;
    logic [CFG_W-1:0]     rem_reg;
    logic [CFG_W:0]       shifted;
    logic [CFG_W:0]       diff;

    // shift in the next dividend bit, subtract when it fits
    assign shifted = {rem_reg, dvd_reg[RAND_W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= DIV_CNT_W'(DIV_STEPS);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= (shifted >= {1'b0, dsr_reg}) ? diff[CFG_W-1:0] : shifted[CFG_W-1:0];
            dvd_reg <= {dvd_reg[RAND_W-2:0], 1'b0};
        end
    end

    assign busy      = (cnt_reg != '0);
    assign remainder = rem_reg;

endmodule

@@ rtl/pkrl_table.sv @@
// ----------------------------------------------------------------------------
// pkrl_table
// bucket memory (key and next-allowed time per way) with per-way valid flops
// ----------------------------------------------------------------------------
module pkrl_table (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rd_en,
    input  pkrl_pkg::bucket_t  rd_addr,
    output pkrl_pkg::row_t     rd_row,
    output pkrl_pkg::way_vec_t rd_valid,
    input  pkrl_pkg::pkrl_wr_t wr
);
    import pkrl_pkg::*;

    row_t     mem [NBUCKETS];
    row_t     rd_row_reg;
    way_vec_t rd_valid_reg;
    way_vec_t valid_reg [NBUCKETS];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.row;
        end
        if (rd_en)
        begin
            rd_row_reg <= mem[rd_addr];
        end
    end

    // valid bits cleared at once by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < NBUCKETS; b++)
            begin
                valid_reg[b] <= '0;
            end
            rd_valid_reg <= '0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= wr.valid;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_row   = rd_row_reg;
    assign rd_valid = rd_valid_reg;

endmodule

@@ rtl/per_key_interval_rate_limiter_top.sv @@
// ----------------------------------------------------------------------------
// per_key_interval_rate_limiter_top
// per-key minimum-interval rate limiter with random jitter
// ----------------------------------------------------------------------------
//  channel | signals                       | beat
//  --------+-------------------------------+------------------------------------
//  req     | req_valid, req_stall, req     | command, caller key, time, random
//  rsp     | rsp_valid, rsp_stall, rsp     | allowed, not recorded
//  cfg     | cfg_valid, cfg_ready, cfg_*   | register index and data
//
//  one request at a time: a check waits in S_WAIT for the 32-step serial
//  remainder unit that makes the jitter; a release does not wait for it, and a
//  check with the limiter off goes from S_IDLE straight to S_RESULT
//  row read, modify and write-back finish before the next read, no forwarding
//  reset clears the valid flops of all entries at once, no clearing pass
//  a stalled result beat in the output register holds the next one in S_RESULT
// ----------------------------------------------------------------------------
module per_key_interval_rate_limiter_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  pkrl_pkg::pkrl_req_t             req,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output pkrl_pkg::pkrl_rsp_t             rsp,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pkrl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pkrl_pkg::CFG_W-1:0]      cfg_data
);
    import pkrl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_WAIT,
        S_CALC,
        S_RESULT
    } state_t;

    state_t    state_reg;
    state_t    state_next;

    // configuration
    logic             enable_reg;
    logic [CFG_W-1:0] min_interval_reg;
    logic [CFG_W-1:0] jitter_span_reg;

    // output register
    logic      rsp_valid_reg;
    pkrl_rsp_t rsp_reg;
    pkrl_rsp_t rsp_next;

    // item and working values
    pkrl_req_t          item_reg;
    logic [KEY_W-1:0]   key_reg;
    logic               bypass_reg;
    way_vec_t           hit_vec_reg;
    way_vec_t           free_vec_reg;
    logic [TIME_W:0]    sum_reg;
    logic               too_soon_reg;

    logic               accept;
    logic               out_free;
    logic [KEY_W-1:0]   key_in;
    way_vec_t           hit_vec;
    way_vec_t           free_vec;
    logic               free_found;
    logic [TIME_W-1:0]  hit_time;
    logic [CFG_W-1:0]   jit;
    logic [TIME_W-1:0]  next_time;

    // table and remainder unit
    row_t     rd_row;
    way_vec_t rd_valid;
    pkrl_wr_t wr;
    logic     div_busy;
    logic [CFG_W-1:0] div_rem;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign cfg_ready = 1'b1;
    assign key_in    = req.caller_key & KEY_MASK;

    pkrl_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (key_in[BUCKET_BITS-1:0]),
        .rd_row   (rd_row),
        .rd_valid (rd_valid),
        .wr       (wr)
    );

    pkrl_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .dividend  (req.random_word),
        .divisor   (jitter_span_reg),
        .busy      (div_busy),
        .remainder (div_rem)
    );

    // way match and lowest free way on the row just read
    always_comb
    begin
        hit_vec    = '0;
        free_vec   = '0;
        free_found = 1'b0;
        for (int w = 0; w < WAYS; w++)
        begin
            hit_vec[w] = rd_valid[w] && (rd_row[w].key == key_reg);
            if (!rd_valid[w] && !free_found)
            begin
                free_vec[w] = 1'b1;
                free_found  = 1'b1;
            end
        end
    end

    // stored time of the matching way
    always_comb
    begin
        hit_time = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (hit_vec_reg[w])
            begin
                hit_time = hit_time | rd_row[w].next_allowed;
            end
        end
    end

    // zero span means no jitter
    assign jit       = (jitter_span_reg == '0) ? '0 : div_rem;
    // saturate at the top of the time range
    assign next_time = sum_reg[TIME_W] ? {TIME_W{1'b1}} : sum_reg[TIME_W-1:0];

    // decision and row write-back
    always_comb
    begin
        rsp_next              = '0;
        rsp_next.allowed      = 1'b1;
        rsp_next.not_recorded = 1'b0;
        wr       = '0;
        wr.addr  = key_reg[BUCKET_BITS-1:0];
        wr.row   = rd_row;
        wr.valid = rd_valid;
        if (!bypass_reg)
        begin
            if (item_reg.command == CMD_RELEASE)
            begin
                if (hit_vec_reg != '0)
                begin
                    wr.en    = 1'b1;
                    wr.valid = rd_valid & ~hit_vec_reg;
                end
            end
            else if (hit_vec_reg != '0)
            begin
                if (too_soon_reg)
                begin
                    rsp_next.allowed = 1'b0;
                end
                else
                begin
                    wr.en = 1'b1;
                    for (int w = 0; w < WAYS; w++)
                    begin
                        if (hit_vec_reg[w])
                        begin
                            wr.row[w].next_allowed = next_time;
                        end
                    end
                end
            end
            else if (free_vec_reg != '0)
            begin
                wr.en    = 1'b1;
                wr.valid = rd_valid | free_vec_reg;
                for (int w = 0; w < WAYS; w++)
                begin
                    if (free_vec_reg[w])
                    begin
                        wr.row[w].key          = key_reg;
                        wr.row[w].next_allowed = next_time;
                    end
                end
            end
            else
            begin
                rsp_next.not_recorded = 1'b1;
            end
        end
        // commit only on the cycle the result is loaded
        wr.en = wr.en && (state_reg == S_RESULT) && out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.command == CMD_CHECK && !enable_reg)
                    begin
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_LOOKUP;
                    end
                end
            end
            S_LOOKUP:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (item_reg.command == CMD_RELEASE || !div_busy)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state, configuration and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            enable_reg       <= RST_ENABLE;
            min_interval_reg <= RST_MIN_INTERVAL;
            jitter_span_reg  <= RST_JITTER_SPAN;
            rsp_valid_reg    <= 1'b0;
            rsp_reg          <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_ENABLE:       enable_reg       <= cfg_data[0];
                    REG_MIN_INTERVAL: min_interval_reg <= cfg_data;
                    REG_JITTER_SPAN:  jitter_span_reg  <= cfg_data;
                    default:          ;
                endcase
            end
            if (state_reg == S_RESULT && out_free)
            begin
                rsp_valid_reg <= 1'b1;
                rsp_reg       <= rsp_next;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // working values of the current request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg   <= req;
            key_reg    <= key_in;
            bypass_reg <= (req.command == CMD_CHECK) && !enable_reg;
        end
        if (state_reg == S_LOOKUP)
        begin
            hit_vec_reg  <= hit_vec;
            free_vec_reg <= free_vec;
        end
        if (state_reg == S_CALC)
        begin
            sum_reg      <= {1'b0, item_reg.now_ms} + (TIME_W+1)'(min_interval_reg)
                            + (TIME_W+1)'(jit);
            too_soon_reg <= item_reg.now_ms < hit_time;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // a key lives in at most one way of its bucket
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAIT) |-> $onehot0(hit_vec_reg))
        else $error("key found in more than one way");

    // the jitter is ready before a check computes its next time
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CALC && item_reg.command == CMD_CHECK) |-> !div_busy)
        else $error("remainder unit still busy at time update");

    // the table is written only when a result is loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |=> (rsp_valid_reg && state_reg == S_IDLE))
        else $error("table write without a result");

    // a refused store is still an allowed request
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.not_recorded) |-> rsp_reg.allowed)
        else $error("unrecorded request reported as denied");

endmodule

@@ verif/per_key_interval_rate_limiter_checker.sv @@
// ----------------------------------------------------------------------------
// per_key_interval_rate_limiter_checker
// watches the request, result and register channels of the rate limiter,
// keeps its own copy of the key table and registers, works out the verdict
// of every accepted request beat and compares it with the result beats
// ----------------------------------------------------------------------------
module per_key_interval_rate_limiter_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    input  logic                            req_stall,
    input  pkrl_pkg::pkrl_req_t             req,
    input  logic                            rsp_valid,
    input  logic                            rsp_stall,
    input  pkrl_pkg::pkrl_rsp_t             rsp,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [pkrl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pkrl_pkg::CFG_W-1:0]      cfg_data,
    output int                              outstanding,
    output int                              failures
);
    import pkrl_pkg::*;

    localparam int                NENTRIES     = NBUCKETS * WAYS;
    localparam logic [TIME_W-1:0] TIME_CEIL    = '1;
    localparam int                REPORT_LIMIT = 10;

    logic             lim_enable;
    logic [CFG_W-1:0] lim_min_ms;
    logic [CFG_W-1:0] lim_span_ms;

    logic              tbl_valid [NENTRIES];
    logic [KEY_W-1:0]  tbl_key   [NENTRIES];
    logic [TIME_W-1:0] tbl_next  [NENTRIES];

    pkrl_rsp_t verdict_q [$];

    // now plus interval plus jitter, held at the top of the time range
    function automatic logic [TIME_W-1:0] next_allowed_time(input logic [TIME_W-1:0] now,
                                                            input logic [RAND_W-1:0] rnd);
        logic [63:0]       sum;
        logic [RAND_W-1:0] jitter;
        jitter = (lim_span_ms == '0) ? '0 : rnd % RAND_W'(lim_span_ms);
        sum    = 64'(now) + 64'(lim_min_ms) + 64'(jitter);
        return (sum > 64'(TIME_CEIL)) ? TIME_CEIL : sum[TIME_W-1:0];
    endfunction

    // verdict of one request, updating the table copy on the way
    function automatic pkrl_rsp_t judge_request(input pkrl_req_t r);
        logic [KEY_W-1:0] key;
        int               base;
        int               hit;
        int               slot;
        pkrl_rsp_t        v;
        key            = r.caller_key & KEY_MASK;
        base           = int'(key[BUCKET_BITS-1:0]) * WAYS;
        v.allowed      = 1'b1;
        v.not_recorded = 1'b0;
        hit            = -1;
        slot           = -1;
        for (int w = 0; w < WAYS; w++)
        begin
            if (hit < 0 && tbl_valid[base+w] && tbl_key[base+w] == key)
                hit = base + w;
            if (slot < 0 && !tbl_valid[base+w])
                slot = base + w;
        end
        if (r.command == CMD_RELEASE)
        begin
            if (hit >= 0)
                tbl_valid[hit] = 1'b0;
        end
        else if (lim_enable)
        begin
            if (hit >= 0)
            begin
                if (r.now_ms < tbl_next[hit])
                    v.allowed = 1'b0;
                else
                    tbl_next[hit] = next_allowed_time(r.now_ms, r.random_word);
            end
            else if (slot < 0)
                v.not_recorded = 1'b1;
            else
            begin
                tbl_valid[slot] = 1'b1;
                tbl_key[slot]   = key;
                tbl_next[slot]  = next_allowed_time(r.now_ms, r.random_word);
            end
        end
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        pkrl_rsp_t want;
        int        pend_delta;
        int        fail_delta;
        if (!rst_n)
        begin
            lim_enable  = RST_ENABLE;
            lim_min_ms  = RST_MIN_INTERVAL;
            lim_span_ms = RST_JITTER_SPAN;
            for (int i = 0; i < NENTRIES; i++)
                tbl_valid[i] = 1'b0;
            verdict_q.delete();
            outstanding <= 0;
            failures    <= 0;
        end
        else
        begin
            pend_delta = 0;
            fail_delta = 0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ENABLE:       lim_enable  = cfg_data[0];
                    REG_MIN_INTERVAL: lim_min_ms  = cfg_data;
                    REG_JITTER_SPAN:  lim_span_ms = cfg_data;
                    default:          ;
                endcase
            end
            // result side first so a stray beat never pairs with this edge's request
            if (rsp_valid && !rsp_stall)
            begin
                if (verdict_q.size() == 0)
                begin
                    fail_delta = 1;
                    if (failures < REPORT_LIMIT)
                        $display("%0t: result beat with nothing pending: %s=%0b %s=%0b",
                                 $time, "allowed", rsp.allowed,
                                 "not_recorded", rsp.not_recorded);
                end
                else
                begin
                    want       = verdict_q.pop_front();
                    pend_delta = -1;
                    if (rsp.allowed !== want.allowed ||
                        rsp.not_recorded !== want.not_recorded)
                    begin
                        fail_delta = 1;
                        if (failures < REPORT_LIMIT)
                            $display({"%0t: mismatch: allowed exp %0b got %0b, ",
                                      "not_recorded exp %0b got %0b"},
                                     $time, want.allowed, rsp.allowed,
                                     want.not_recorded, rsp.not_recorded);
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                verdict_q.push_back(judge_request(req));
                pend_delta = pend_delta + 1;
            end
            outstanding <= outstanding + pend_delta;
            failures    <= failures + fail_delta;
        end
    end

endmodule

@@ verif/per_key_interval_rate_limiter_top_tb.sv @@
// ----------------------------------------------------------------------------
// per_key_interval_rate_limiter_top_tb
// drives the rate limiter with a short directed run and then phases of
// random requests built around small pools of colliding keys, under several
// register settings and idling patterns; the checker beside the block
// predicts and compares, this module only makes stimulus and gives a verdict
// ----------------------------------------------------------------------------
module per_key_interval_rate_limiter_top_tb;

    import pkrl_pkg::*;

    localparam int                CYCLE_LIMIT = 1000000;
    localparam int                TAIL_CYCLES = 48;     // a little over one check
    localparam int                PHASE_ITEMS = 250;
    localparam int                NPHASES     = 6;
    localparam int                POOL_SIZE   = 16;
    localparam logic [TIME_W-1:0] TIME_TOP    = '1;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    pkrl_req_t            req       = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    pkrl_rsp_t            rsp;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    int outstanding;
    int mismatches;
    int cycle_count = 0;

    // idling odds in percent, changed between phases
    int tx_idle_pct = 21;
    int rx_idle_pct = 69;

    // keys of the current random phase, crowded into at most three buckets
    logic [KEY_W-1:0]  key_pool [POOL_SIZE];
    // running wall clock of the well-formed traffic
    logic [TIME_W-1:0] clock_ms;

    per_key_interval_rate_limiter_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    per_key_interval_rate_limiter_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .failures    (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver back-pressure, independent of rsp_valid
    always @(posedge clk)
        rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);

    // watchdog on a hung handshake or a lost result beat
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic pkrl_req_t req_beat(input logic cmd, input logic [KEY_W-1:0] key,
                                           input logic [TIME_W-1:0] now,
                                           input logic [RAND_W-1:0] rnd);
        pkrl_req_t b;
        b.command     = cmd;
        b.caller_key  = key;
        b.now_ms      = now;
        b.random_word = rnd;
        return b;
    endfunction

    // one request beat; called at a rising edge, returns at the accepting edge
    // with valid still high so back-to-back beats never drop it
    task automatic send_beat(input pkrl_req_t b);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= b;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    // sender holds off until every result beat has come back
    task automatic drain_results;
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // all three registers in one burst, valid held high between writes
    task automatic set_limits(input logic en, input logic [CFG_W-1:0] min_v,
                              input logic [CFG_W-1:0] span_v);
        logic [CFG_IDX_W-1:0] idx [3];
        logic [CFG_W-1:0]     val [3];
        idx = '{REG_ENABLE, REG_MIN_INTERVAL, REG_JITTER_SPAN};
        val = '{CFG_W'(en), min_v, span_v};
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_directed;
        // reset registers: interval 30000, span 10000
        send_beat(req_beat(CMD_CHECK,   22'h000001, 48'd0,     32'd0));        // first sight
        send_beat(req_beat(CMD_CHECK,   22'h000001, 48'd29999, 32'd0));        // one ms early
        send_beat(req_beat(CMD_CHECK,   22'h000001, 48'd30000, 32'hFFFFFFFF)); // exactly due
        // fill bucket one and overflow it
        send_beat(req_beat(CMD_CHECK,   22'h000041, 48'd1,     32'd5));
        send_beat(req_beat(CMD_CHECK,   22'h3FFFC1, 48'd2,     32'd5));
        send_beat(req_beat(CMD_CHECK,   22'h2AAA81, 48'd3,     32'd5));
        send_beat(req_beat(CMD_CHECK,   22'h155541, 48'd4,     32'd5));        // bucket full
        send_beat(req_beat(CMD_CHECK,   22'h155541, 48'd5,     32'd5));        // still full
        send_beat(req_beat(CMD_RELEASE, 22'h000041, 48'd0,     32'hFFFFFFFF));
        send_beat(req_beat(CMD_CHECK,   22'h155541, 48'd6,     32'd7));        // takes freed way
        send_beat(req_beat(CMD_RELEASE, 22'h000002, TIME_TOP,  32'd0));        // unknown key
        send_beat(req_beat(CMD_RELEASE, 22'h000041, 48'd0,     32'd0));        // already gone
        // next-allowed time saturates at the top of the range
        send_beat(req_beat(CMD_CHECK,   22'h3FFFFF, TIME_TOP - 1, 32'hFFFFFFFF));
        send_beat(req_beat(CMD_CHECK,   22'h3FFFFF, TIME_TOP - 2, 32'd0));
        send_beat(req_beat(CMD_CHECK,   22'h3FFFFF, TIME_TOP,     32'd0));
        drain_results();

        // limiter off: checks pass untouched, release still frees
        set_limits(1'b0, '0, '0);
        send_beat(req_beat(CMD_CHECK,   22'h3FFFFF, 48'd0, 32'd0));
        send_beat(req_beat(CMD_CHECK,   22'h000081, 48'd0, 32'd0));            // full bucket, off
        send_beat(req_beat(CMD_RELEASE, 22'h3FFFFF, 48'd0, 32'd0));
        drain_results();

        // widest interval and span
        set_limits(1'b1, '1, '1);
        send_beat(req_beat(CMD_CHECK, 22'h3FFFFF, 48'd0,       32'd0));
        send_beat(req_beat(CMD_CHECK, 22'h3FFFFF, 48'd1048574, 32'd0));
        send_beat(req_beat(CMD_CHECK, 22'h3FFFFF, 48'd1048575, 32'd12345));
        drain_results();
    endtask

    // mostly well-formed traffic: pool keys on an advancing clock, some
    // releases; the rest is raw noise or times near the top of the range
    task automatic run_random(input int count, input logic [CFG_W-1:0] min_v,
                              input logic [CFG_W-1:0] span_v);
        logic [BUCKET_BITS-1:0] hot [3];
        pkrl_req_t              b;
        int                     step_max;
        int                     pick;
        // step chosen so a pool key comes back roughly one interval later
        step_max = (int'(min_v) + int'(span_v)) / 8 + 1;
        for (int i = 0; i < 3; i++)
            hot[i] = BUCKET_BITS'($urandom);
        for (int p = 0; p < POOL_SIZE; p++)
            key_pool[p] = {(KEY_W-BUCKET_BITS)'($urandom), hot[$urandom_range(0, 2)]};
        clock_ms = TIME_W'({16'($urandom_range(0, 32767)), $urandom});
        for (int n = 0; n < count; n++)
        begin
            pick          = $urandom_range(0, 99);
            b.random_word = $urandom;
            if (pick < 10)
            begin
                b.command    = 1'($urandom);
                b.caller_key = KEY_W'($urandom);
                b.now_ms     = TIME_W'({$urandom, $urandom});
            end
            else
            begin
                b.caller_key = key_pool[$urandom_range(0, POOL_SIZE-1)];
                b.command    = ($urandom_range(0, 99) < 15) ? CMD_RELEASE : CMD_CHECK;
                if (pick < 14)
                    b.now_ms = TIME_TOP - TIME_W'($urandom_range(0, step_max * 8));
                else
                begin
                    clock_ms = clock_ms + TIME_W'($urandom_range(0, step_max));
                    b.now_ms = clock_ms;
                end
            end
            send_beat(b);
        end
    endtask

    initial
    begin : stimulus
        logic             en_v;
        logic [CFG_W-1:0] min_v;
        logic [CFG_W-1:0] span_v;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part runs on the reset register values first
        run_directed();

        for (int ph = 0; ph < NPHASES; ph++)
        begin
            case (ph)
                0:       begin en_v = 1'b1; min_v = 20'd100;  span_v = 20'd64;   end
                1:       begin en_v = 1'b1; min_v = 20'd0;    span_v = 20'd1;    end
                2:       begin en_v = 1'b0; min_v = 20'd500;  span_v = 20'd100;  end
                3:       begin en_v = 1'b1; min_v = '1;       span_v = '1;       end
                4:       begin en_v = 1'b1; min_v = 20'd300;  span_v = 20'd0;    end
                default: begin en_v = 1'b1; min_v = 20'd2000; span_v = 20'd1000; end
            endcase
            // sender-light/receiver-heavy, then swapped, then no idling at all
            if (ph == 2)
            begin
                tx_idle_pct = 69;
                rx_idle_pct = 21;
            end
            else if (ph == 4)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            set_limits(en_v, min_v, span_v);
            run_random(PHASE_ITEMS, min_v, span_v);
            drain_results();
        end

        // room for any stray late beat to show up
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
